[design/set_assoc_lru_cache_timing_core_defines.svh]
// assertion helpers
`ifndef SET_ASSOC_LRU_CACHE_TIMING_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TIMING_CORE_DEFINES_SVH
`define SALC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SALC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[design/salc_pkg.sv]
`default_nettype none
package salc_pkg;
   localparam int SET_COUNT_DEF   = 64;
   localparam int NUM_WAYS_DEF    = 4;
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int ADDR_BITS_DEF   = 32;
   localparam int LAT_W = 10;
   localparam int PEN_W = 11;
   localparam int TIME_W = 32;
   localparam logic CSR_MEM_LAT = 1'b0;
   localparam logic CSR_WB_LAT  = 1'b1;
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_CLEAN = 2'd2;
   localparam logic [1:0] OUT_DIRTY = 2'd3;

   typedef struct packed {
      logic load;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } status_type;
endpackage
`default_nettype wire

[design/salc_ctrl.sv]
`default_nettype none
module salc_ctrl (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire  rsp_ready,
   input  salc_pkg::status_type status,
   output salc_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOOK = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   always_comb begin
      state_in = state_ff;
      rv_in = rv_ff;
      cmd = '0;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = !status.clearing && (!rv_ff || rsp_ready);
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.update = 1'b1;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
endmodule
`default_nettype wire

[design/salc_datapath.sv]
`default_nettype none
module salc_datapath #(
   parameter int SET_COUNT   = salc_pkg::SET_COUNT_DEF,
   parameter int NUM_WAYS    = salc_pkg::NUM_WAYS_DEF,
   parameter int BLOCK_BYTES = salc_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
   input  wire  clock,
   input  wire  reset,
   input  salc_pkg::cmd_type cmd,
   output salc_pkg::status_type status,
   input  wire  [31:0] req_address,
   input  wire  req_is_write,
   input  wire  [31:0] req_access_time,
   input  wire  [salc_pkg::LAT_W-1:0] mem_lat,
   input  wire  [salc_pkg::LAT_W-1:0] wb_lat,
   output logic rsp_hit,
   output logic [1:0] rsp_outcome,
   output logic rsp_writeback,
   output logic [salc_pkg::PEN_W-1:0] rsp_penalty
);
   localparam int OB = $clog2(BLOCK_BYTES);
   localparam int SBR = $clog2(SET_COUNT);
   localparam int SB = (SBR < 1) ? 1 : SBR;
   localparam int TB = (ADDR_BITS - OB - SBR < 1) ? 1 : ADDR_BITS - OB - SBR;
   localparam int WB = (NUM_WAYS < 2) ? 1 : $clog2(NUM_WAYS);
   localparam int TW = salc_pkg::TIME_W;

   logic [TB-1:0] tag_mem [SET_COUNT][NUM_WAYS];
   logic [TW-1:0] stamp_mem [SET_COUNT][NUM_WAYS];
   logic [NUM_WAYS-1:0] valid_mem [SET_COUNT];
   logic [NUM_WAYS-1:0] dirty_mem [SET_COUNT];

   logic [SB-1:0] clr_ff;
   logic clearing_ff;

   logic [SB-1:0] set_ff;
   logic [TB-1:0] tag_ff;
   logic wr_ff;
   logic [TW-1:0] now_ff;
   logic [TB-1:0] rtag_ff [NUM_WAYS];
   logic [TW-1:0] rstamp_ff [NUM_WAYS];
   logic [NUM_WAYS-1:0] rvalid_ff, rdirty_ff;

   logic [ADDR_BITS-1:0] addr;
   logic [SB-1:0] set_raw, set_idx;
   logic [TB-1:0] tag_in;
   always_comb begin
      addr = req_address[ADDR_BITS-1:0];
      if (SBR == 0) set_raw = '0;
      else set_raw = SB'(addr >> OB);
      set_idx = set_raw;
      if ({1'b0, set_raw} >= (SB+1)'(SET_COUNT))
         set_idx = SB'({1'b0, set_raw} - (SB+1)'(SET_COUNT));
      if ({1'b0, set_idx} >= (SB+1)'(SET_COUNT)) set_idx = '0;
      if (ADDR_BITS - OB - SBR < 1) tag_in = '0;
      else tag_in = TB'(addr >> (OB + SBR));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if ({1'b0, clr_ff} == (SB+1)'(SET_COUNT - 1)) clearing_ff <= 1'b0;
      end
   end
   assign status.clearing = clearing_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         set_ff <= set_idx;
         tag_ff <= tag_in;
         wr_ff <= req_is_write;
         now_ff <= req_access_time;
         for (int w = 0; w < NUM_WAYS; w++) begin
            rtag_ff[w] <= tag_mem[set_idx][w];
            rstamp_ff[w] <= stamp_mem[set_idx][w];
         end
         rvalid_ff <= valid_mem[set_idx];
         rdirty_ff <= dirty_mem[set_idx];
      end
   end

   logic hit_c, free_c;
   logic [WB-1:0] hw, fw, vw, pick;
   logic [TW-1:0] best;
   logic [salc_pkg::LAT_W:0] sum;
   logic [salc_pkg::PEN_W-1:0] pm, pmw;
   always_comb begin
      hit_c = 1'b0; hw = '0;
      free_c = 1'b0; fw = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (rvalid_ff[w] && rtag_ff[w] == tag_ff) begin hit_c = 1'b1; hw = WB'(w); end
         if (!rvalid_ff[w]) begin free_c = 1'b1; fw = WB'(w); end
      end
      vw = '0; best = rstamp_ff[0];
      for (int w = 1; w < NUM_WAYS; w++)
         if (rstamp_ff[w] < best) begin best = rstamp_ff[w]; vw = WB'(w); end
      pick = hit_c ? hw : (free_c ? fw : vw);
      pm = (mem_lat == '0) ? '0 : salc_pkg::PEN_W'(mem_lat) - 1'b1;
      sum = {1'b0, mem_lat} + {1'b0, wb_lat};
      pmw = (sum == '0) ? '0 : salc_pkg::PEN_W'(sum) - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         valid_mem[clr_ff] <= '0;
         dirty_mem[clr_ff] <= '0;
      end else if (cmd.update) begin
         valid_mem[set_ff][pick] <= 1'b1;
         stamp_mem[set_ff][pick] <= now_ff;
         if (hit_c) begin
            if (wr_ff) dirty_mem[set_ff][pick] <= 1'b1;
         end else begin
            dirty_mem[set_ff][pick] <= wr_ff;
            tag_mem[set_ff][pick] <= tag_ff;
         end
      end
      if (cmd.update) begin
         rsp_hit <= hit_c;
         if (hit_c) begin
            rsp_outcome <= salc_pkg::OUT_HIT; rsp_writeback <= 1'b0; rsp_penalty <= '0;
         end else if (free_c) begin
            rsp_outcome <= salc_pkg::OUT_FILL; rsp_writeback <= 1'b0; rsp_penalty <= pm;
         end else if (rdirty_ff[vw]) begin
            rsp_outcome <= salc_pkg::OUT_DIRTY; rsp_writeback <= 1'b1; rsp_penalty <= pmw;
         end else begin
            rsp_outcome <= salc_pkg::OUT_CLEAN; rsp_writeback <= 1'b0; rsp_penalty <= pm;
         end
      end
   end
endmodule
`default_nettype wire

[design/set_assoc_lru_cache_timing_core.sv]
// rsp_valid is registered: the accepting edge reads the set, then the S_LOOK update
// writes the tag store and sets rsp_valid.
// A new request is not taken until the read-then-write of the tag store has finished.
// Reset: synchronous; a clearing pass over all SET_COUNT sets wipes valid and dirty
// bits, during which no request is taken. Latencies reset to 100 and 10.
`default_nettype none
module set_assoc_lru_cache_timing_core #(
   parameter int SET_COUNT   = salc_pkg::SET_COUNT_DEF,
   parameter int NUM_WAYS    = salc_pkg::NUM_WAYS_DEF,
   parameter int BLOCK_BYTES = salc_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_valid,
   output logic req_ready,
   input  wire  [31:0] req_address,
   input  wire  req_is_write,
   input  wire  [31:0] req_access_time,
   output logic rsp_valid,
   input  wire  rsp_ready,
   output logic rsp_hit,
   output logic [1:0] rsp_outcome,
   output logic rsp_writeback,
   output logic [10:0] rsp_penalty,
   input  wire  csr_we,
   input  wire  [0:0] csr_index,
   input  wire  [9:0] csr_wdata
);
   salc_pkg::cmd_type cmd;
   salc_pkg::status_type status;
   logic [9:0] mem_lat_ff, wb_lat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_lat_ff <= 10'd100;
         wb_lat_ff <= 10'd10;
      end else if (csr_we) begin
         case (csr_index)
            salc_pkg::CSR_MEM_LAT: mem_lat_ff <= csr_wdata;
            salc_pkg::CSR_WB_LAT:  wb_lat_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   salc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd)
   );

   salc_datapath #(
      .SET_COUNT(SET_COUNT), .NUM_WAYS(NUM_WAYS),
      .BLOCK_BYTES(BLOCK_BYTES), .ADDR_BITS(ADDR_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_address(req_address), .req_is_write(req_is_write),
      .req_access_time(req_access_time), .mem_lat(mem_lat_ff), .wb_lat(wb_lat_ff),
      .rsp_hit(rsp_hit), .rsp_outcome(rsp_outcome), .rsp_writeback(rsp_writeback),
      .rsp_penalty(rsp_penalty)
   );
endmodule
`default_nettype wire

[design/salc_checker.sv]
`default_nettype none
`include "set_assoc_lru_cache_timing_core_defines.svh"
module salc_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_hit,
   input wire [1:0] rsp_outcome,
   input wire rsp_writeback
);
   `SALC_ASSERT_NXT(a_req_gives_rsp, clock, reset, req_valid && req_ready, ##1 rsp_valid)
   `SALC_ASSERT_NXT(a_no_take_after, clock, reset, req_valid && req_ready, !req_ready)
   `SALC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SALC_ASSERT_IMP(a_hit_code, clock, reset, rsp_valid, rsp_hit == (rsp_outcome == salc_pkg::OUT_HIT))
   `SALC_ASSERT_IMP(a_wb_code, clock, reset, rsp_valid, rsp_writeback == (rsp_outcome == salc_pkg::OUT_DIRTY))
endmodule

bind set_assoc_lru_cache_timing_core salc_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
   .rsp_outcome(rsp_outcome), .rsp_writeback(rsp_writeback)
);
`default_nettype wire
